/* rtl/babnd_pkg.sv */
// ----------------------------------------------------------------------------
// babnd_pkg: shared types and constants of the binary arithmetic decoder
// Command and status codes, controller states, and the command and status
// bundles that run between controller and datapath.
// ----------------------------------------------------------------------------
package babnd_pkg;

    // Sizes
    parameter int QUEUE_BYTES = 32;
    parameter int CONTEXTS    = 128;
    parameter int QPTR_W      = $clog2(QUEUE_BYTES);
    parameter int QCNT_W      = $clog2(QUEUE_BYTES + 1);
    parameter int CTX_W       = $clog2(CONTEXTS);
    parameter int PROB_W      = 16;
    parameter int RANGE_W     = 16;
    parameter int MUL_W       = 24;
    parameter int NORM_MAX    = 16;
    parameter int BITCNT_W    = $clog2(NORM_MAX + 1);
    parameter int NUM_GROUPS  = 8;
    parameter int GRP_W       = $clog2(NUM_GROUPS);

    typedef enum logic [2:0] {
        CMD_LOAD_BYTE  = 3'd0,
        CMD_WRITE_PROB = 3'd1,
        CMD_START      = 3'd2,
        CMD_DECODE_BIT = 3'd3,
        CMD_DECODE_NUM = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_UNDERRUN = 2'd1,
        STS_FULL     = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START_BIT,
        S_START_LOAD,
        S_PROB,
        S_MUL,
        S_CMP,
        S_NORM,
        S_NORM_LOAD,
        S_NEXT,
        S_RESP
    } t_state;

    // Which part of a decode is running
    typedef enum logic [1:0] {
        M_BIT,
        M_SEL,
        M_OFF
    } t_mode;

    // Controller to datapath
    typedef struct packed {
        logic    q_write;
        logic    prob_write;
        logic    prob_read;
        logic    ctx_off;
        logic    mul;
        logic    decide;
        logic    step_bit;
        logic    fetch;
        logic    take_byte;
        logic    shift_range;
        logic    start_init;
        logic    num_init;
        logic    num_next_sel;
        logic    num_group;
        logic    num_offset;
        logic    value_bit;
        logic    value_max;
        logic    out_load;
        logic    out_zero;
        t_status out_status;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic q_full;
        logic q_empty;
        logic bit_avail;
        logic range_msb;
        logic bit_val;
        logic k_zero;
        logic k_last;
        logic i_last;
    } t_dp_stat;

endpackage

/* rtl/babnd_dp.sv */
// ----------------------------------------------------------------------------
// babnd_dp: decoder datapath
// Range and code registers, sub-range multiplier, bit reader over the byte
// queue memory, probability table memory, number accumulation and the
// output register.
// ----------------------------------------------------------------------------
module babnd_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  babnd_pkg::t_dp_cmd             i_cmd,
    input  logic [7:0]                     i_data_byte,
    input  logic [babnd_pkg::CTX_W-1:0]    i_context_req,
    input  logic [babnd_pkg::PROB_W-1:0]   i_prob_word,
    output babnd_pkg::t_dp_stat            o_stat,
    output logic [7:0]                     o_value,
    output logic [1:0]                     o_status
);
    import babnd_pkg::*;

    // Arithmetic state
    logic [RANGE_W-1:0] r_range, n_range;
    logic [RANGE_W-1:0] r_code, n_code;
    logic [PROB_W-1:0]  r_prob_q;
    logic [MUL_W-1:0]   r_prod;
    logic               r_bit;

    // Bit reader and queue
    logic [7:0]         r_shift, n_shift;
    logic [7:0]         r_mask, n_mask;
    logic [QPTR_W-1:0]  r_head, r_tail;
    logic [QCNT_W-1:0]  r_count;
    logic [7:0]         r_q_rd;
    logic [7:0]         r_queue_mem [QUEUE_BYTES];
    logic [PROB_W-1:0]  r_prob_mem [CONTEXTS];

    // Number decode
    logic [CTX_W-1:0]   r_base;
    logic [GRP_W-1:0]   r_k;
    logic [GRP_W-1:0]   r_i;
    logic [7:0]         r_value;

    // Output register
    logic [7:0]         r_out_value;
    logic [1:0]         r_out_status;

    logic [CTX_W-1:0]   w_ctx;
    logic [RANGE_W-1:0] w_p_raw;
    logic [RANGE_W-1:0] w_p;
    logic               w_ge;
    logic [7:0]         w_next_mask;
    logic               w_bit;
    logic               w_in_bit;

    // Select context: selector group or offset bit
    assign w_ctx = r_base + (i_cmd.ctx_off ? (CTX_W'(8) + CTX_W'(r_i)) : CTX_W'(r_k));

    // Sub-range with a floor of one, and the compare against code
    assign w_p_raw = r_prod[MUL_W-1:MUL_W-RANGE_W];
    assign w_p     = (w_p_raw == '0) ? RANGE_W'(1) : w_p_raw;
    assign w_ge    = (r_code >= w_p);

    // Next stream bit out of the current byte
    assign w_next_mask = {1'b0, r_mask[7:1]};
    assign w_bit       = |(r_shift & w_next_mask);
    assign w_in_bit    = i_cmd.take_byte ? r_q_rd[7] : w_bit;

    // Range, code and bit reader update
    always_comb begin
        n_range = r_range;
        n_code  = r_code;
        n_shift = r_shift;
        n_mask  = r_mask;
        if (i_cmd.start_init) begin
            n_range = '1;
            n_code  = '0;
            n_shift = '0;
            n_mask  = '0;
        end else if (i_cmd.decide) begin
            if (w_ge) begin
                n_code  = r_code - w_p;
                n_range = r_range - w_p;
            end else begin
                n_range = w_p;
            end
        end else if (i_cmd.step_bit || i_cmd.take_byte) begin
            n_code = {r_code[RANGE_W-2:0], w_in_bit};
            if (i_cmd.shift_range) begin
                n_range = {r_range[RANGE_W-2:0], 1'b0};
            end
            if (i_cmd.take_byte) begin
                n_shift = r_q_rd;
                n_mask  = 8'h80;
            end else begin
                n_mask  = w_next_mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range <= '1;
            r_code  <= '0;
            r_shift <= '0;
            r_mask  <= '0;
        end else begin
            r_range <= n_range;
            r_code  <= n_code;
            r_shift <= n_shift;
            r_mask  <= n_mask;
        end
    end

    // Multiply scaled range by probability, latch the decided bit
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= MUL_W'({1'b1, r_range[RANGE_W-2:8]}) * MUL_W'(r_prob_q);
        end
        if (i_cmd.decide) begin
            r_bit <= w_ge;
        end
    end

    // Probability table memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.prob_write) begin
            r_prob_mem[i_context_req] <= i_prob_word;
        end
        if (i_cmd.prob_read) begin
            r_prob_q <= r_prob_mem[w_ctx];
        end
    end

    // Byte queue memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_write) begin
            r_queue_mem[r_tail] <= i_data_byte;
        end
        if (i_cmd.fetch) begin
            r_q_rd <= r_queue_mem[r_head];
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.q_write) begin
                r_tail  <= (r_tail == QPTR_W'(QUEUE_BYTES - 1)) ? '0 : r_tail + QPTR_W'(1);
                r_count <= r_count + QCNT_W'(1);
            end else if (i_cmd.fetch) begin
                r_head  <= (r_head == QPTR_W'(QUEUE_BYTES - 1)) ? '0 : r_head + QPTR_W'(1);
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    // Number accumulation
    always_ff @(posedge i_clk) begin
        if (i_cmd.num_init) begin
            r_base <= i_context_req;
            r_k    <= '0;
            r_i    <= '0;
        end
        if (i_cmd.num_next_sel) begin
            r_k <= r_k + GRP_W'(1);
        end
        if (i_cmd.num_group) begin
            r_value <= (8'd1 << r_k) - 8'd1;
            r_i     <= '0;
        end
        if (i_cmd.num_offset) begin
            if (r_bit) begin
                r_value <= r_value + (8'd1 << r_i);
            end
            r_i <= r_i + GRP_W'(1);
        end
        if (i_cmd.value_bit) begin
            r_value <= {7'd0, r_bit};
        end
        if (i_cmd.value_max) begin
            r_value <= 8'hFF;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value  <= i_cmd.out_zero ? 8'd0 : r_value;
            r_out_status <= i_cmd.out_status;
        end
    end

    assign o_value  = r_out_value;
    assign o_status = r_out_status;

    // Status back to the controller
    assign o_stat.q_full    = (r_count == QCNT_W'(QUEUE_BYTES));
    assign o_stat.q_empty   = (r_count == '0);
    assign o_stat.bit_avail = |r_mask[7:1];
    assign o_stat.range_msb = r_range[RANGE_W-1];
    assign o_stat.bit_val   = r_bit;
    assign o_stat.k_zero    = (r_k == '0);
    assign o_stat.k_last    = (r_k == GRP_W'(NUM_GROUPS - 1));
    assign o_stat.i_last    = (r_i == r_k - GRP_W'(1));

endmodule

/* rtl/babnd_ctrl.sv */
// ----------------------------------------------------------------------------
// babnd_ctrl: decoder controller
// Sequences each command through the datapath: queue writes, code load on
// start, and the multiply, compare and renormalize steps of every bit
// decode, with the group and offset loop of a number decode.
// ----------------------------------------------------------------------------
module babnd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [2:0]           i_command,
    input  logic                 i_out_ready,
    input  babnd_pkg::t_dp_stat  i_stat,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output babnd_pkg::t_dp_cmd   o_cmd
);
    import babnd_pkg::*;

    t_state              r_state, n_state;
    t_mode               r_mode, n_mode;
    t_status             r_res_status, n_res_status;
    logic                r_res_zero, n_res_zero;
    logic                r_underrun, n_underrun;
    logic [BITCNT_W-1:0] r_bitcnt, n_bitcnt;
    logic                r_out_valid, n_out_valid;
    logic                w_cnt_done;
    logic                w_norm_done;
    logic                w_out_free;

    assign w_cnt_done  = (r_bitcnt == BITCNT_W'(NORM_MAX));
    assign w_norm_done = i_stat.range_msb || w_cnt_done;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Next state and sequencing registers
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_res_status = r_res_status;
        n_res_zero   = r_res_zero;
        n_underrun   = r_underrun;
        n_bitcnt     = r_bitcnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_command)
                        CMD_LOAD_BYTE: begin
                            n_res_status = i_stat.q_full ? STS_FULL : STS_OK;
                            n_res_zero   = 1'b1;
                            n_state      = S_RESP;
                        end
                        CMD_WRITE_PROB: begin
                            n_state = S_IDLE;
                        end
                        CMD_START: begin
                            n_underrun = 1'b0;
                            n_bitcnt   = '0;
                            n_state    = S_START_BIT;
                        end
                        CMD_DECODE_BIT, CMD_DECODE_NUM: begin
                            if (r_underrun) begin
                                n_res_status = STS_UNDERRUN;
                                n_res_zero   = 1'b1;
                                n_state      = S_RESP;
                            end else begin
                                n_mode  = (i_command == CMD_DECODE_BIT) ? M_BIT : M_SEL;
                                n_state = S_PROB;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_START_BIT: begin
                if (w_cnt_done) begin
                    n_res_status = STS_OK;
                    n_res_zero   = 1'b1;
                    n_state      = S_RESP;
                end else if (i_stat.bit_avail) begin
                    n_bitcnt = r_bitcnt + BITCNT_W'(1);
                end else if (i_stat.q_empty) begin
                    n_underrun   = 1'b1;
                    n_res_status = STS_UNDERRUN;
                    n_res_zero   = 1'b1;
                    n_state      = S_RESP;
                end else begin
                    n_state = S_START_LOAD;
                end
            end
            S_START_LOAD: begin
                n_bitcnt = r_bitcnt + BITCNT_W'(1);
                n_state  = S_START_BIT;
            end
            S_PROB: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                n_bitcnt = '0;
                n_state  = S_NORM;
            end
            S_NORM: begin
                if (w_norm_done) begin
                    n_state = S_NEXT;
                end else if (i_stat.bit_avail) begin
                    n_bitcnt = r_bitcnt + BITCNT_W'(1);
                end else if (i_stat.q_empty) begin
                    n_underrun   = 1'b1;
                    n_res_status = STS_UNDERRUN;
                    n_res_zero   = 1'b1;
                    n_state      = S_RESP;
                end else begin
                    n_state = S_NORM_LOAD;
                end
            end
            S_NORM_LOAD: begin
                n_bitcnt = r_bitcnt + BITCNT_W'(1);
                n_state  = S_NORM;
            end
            S_NEXT: begin
                n_res_status = STS_OK;
                n_res_zero   = 1'b0;
                case (r_mode)
                    M_BIT: begin
                        n_state = S_RESP;
                    end
                    M_SEL: begin
                        if (i_stat.bit_val) begin
                            if (i_stat.k_zero) begin
                                n_state = S_RESP;
                            end else begin
                                n_mode  = M_OFF;
                                n_state = S_PROB;
                            end
                        end else if (i_stat.k_last) begin
                            n_state = S_RESP;
                        end else begin
                            n_state = S_PROB;
                        end
                    end
                    M_OFF: begin
                        n_state = i_stat.i_last ? S_RESP : S_PROB;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.out_status = r_res_status;
        o_cmd.out_zero   = r_res_zero;
        o_cmd.ctx_off    = (r_mode == M_OFF);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_command)
                        CMD_LOAD_BYTE: begin
                            o_cmd.q_write = !i_stat.q_full;
                        end
                        CMD_WRITE_PROB: begin
                            o_cmd.prob_write = 1'b1;
                        end
                        CMD_START: begin
                            o_cmd.start_init = 1'b1;
                        end
                        CMD_DECODE_BIT, CMD_DECODE_NUM: begin
                            o_cmd.num_init = !r_underrun;
                        end
                        default: begin
                            o_cmd.num_init = 1'b0;
                        end
                    endcase
                end
            end
            S_START_BIT: begin
                if (!w_cnt_done) begin
                    o_cmd.step_bit = i_stat.bit_avail;
                    o_cmd.fetch    = !i_stat.bit_avail && !i_stat.q_empty;
                end
            end
            S_START_LOAD: begin
                o_cmd.take_byte = 1'b1;
            end
            S_PROB: begin
                o_cmd.prob_read = 1'b1;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
            end
            S_CMP: begin
                o_cmd.decide = 1'b1;
            end
            S_NORM: begin
                o_cmd.shift_range = 1'b1;
                if (!w_norm_done) begin
                    o_cmd.step_bit = i_stat.bit_avail;
                    o_cmd.fetch    = !i_stat.bit_avail && !i_stat.q_empty;
                end
            end
            S_NORM_LOAD: begin
                o_cmd.shift_range = 1'b1;
                o_cmd.take_byte   = 1'b1;
            end
            S_NEXT: begin
                case (r_mode)
                    M_BIT: begin
                        o_cmd.value_bit = 1'b1;
                    end
                    M_SEL: begin
                        if (i_stat.bit_val) begin
                            o_cmd.num_group = 1'b1;
                        end else if (i_stat.k_last) begin
                            o_cmd.value_max = 1'b1;
                        end else begin
                            o_cmd.num_next_sel = 1'b1;
                        end
                    end
                    M_OFF: begin
                        o_cmd.num_offset = 1'b1;
                    end
                    default: begin
                        o_cmd.num_offset = 1'b0;
                    end
                endcase
            end
            S_RESP: begin
                o_cmd.out_load = w_out_free;
            end
            default: begin
                o_cmd.out_load = 1'b0;
            end
        endcase
    end

    // Hold a result until the consumer takes the beat
    assign n_out_valid = o_cmd.out_load || (r_out_valid && !i_out_ready);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= M_BIT;
            r_res_status <= STS_OK;
            r_res_zero   <= 1'b1;
            r_underrun   <= 1'b0;
            r_bitcnt     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_res_status <= n_res_status;
            r_res_zero   <= n_res_zero;
            r_underrun   <= n_underrun;
            r_bitcnt     <= n_bitcnt;
            r_out_valid  <= n_out_valid;
        end
    end

endmodule

/* rtl/binary_arith_bit_number_decoder_top.sv */
// Start loads the code with two bytes fetched from the queue, unless the queue runs empty.
// Decode bit steps through probability read, multiply, compare, renormalizing shifts with byte fetches, result.
// Decode number chains up to 15 bit decodes, each with its own shifts and fetches.
// Throughput: one item at a time; a new item enters once the result is in the output register.
// Reset (sync, active low): range 0xFFFF, code, queue count, bit mask, underrun cleared.
// Probability table and queue contents are not cleared.
// ----------------------------------------------------------------------------
// binary_arith_bit_number_decoder_top: adaptive binary arithmetic decoder
// Joins the controller and the datapath; one result beat for load byte,
// start, decode bit and decode number, none for write prob.
// ----------------------------------------------------------------------------
module binary_arith_bit_number_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_data_byte,
    input  logic [6:0]  i_context_req,
    input  logic [15:0] i_prob_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_value,
    output logic [1:0]  o_status
);
    import babnd_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    babnd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_command),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    babnd_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_data_byte   (i_data_byte),
        .i_context_req (i_context_req),
        .i_prob_word   (i_prob_word),
        .o_stat        (w_stat),
        .o_value       (o_value),
        .o_status      (o_status)
    );

endmodule

/* rtl/babnd_checker.sv */
// ----------------------------------------------------------------------------
// babnd_checker: port-level checks of the decoder
// Watches the top-level ports for output holding, status coding, error
// values and the busy period that follows a start.
// ----------------------------------------------------------------------------
module babnd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [2:0]  i_command,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_value,
    input logic [1:0]  o_status
);
    import babnd_pkg::*;

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_value) && $stable(o_status)))
        else $error("result beat changed while stalled");

    // Only the three defined status codes appear
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status != 2'd3))
        else $error("undefined status code");

    // Error results carry a zero value
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != STS_OK)) |-> (o_value == 8'd0))
        else $error("nonzero value with error status");

    // Start keeps the block busy on the next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_command == CMD_START)) |=> !o_in_ready)
        else $error("input taken during start");

    // Reset drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind binary_arith_bit_number_decoder_top babnd_checker u_babnd_checker (.*);
